### src/lbmeq_pkg.sv
// Shared constants, types and helper functions for the D3Q19 equilibrium core.
// No dependencies; every other file refers to this package by scoped names.
package lbmeq_pkg;

  localparam int unsigned NUM_DIR  = 19;
  localparam int unsigned DIR_W    = 5;
  localparam int unsigned DATA_W   = 24;
  localparam int unsigned WEIGHT_W = 16;

  // APB register map, byte addresses 4*index
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned CFG_DW    = 32;
  localparam logic [1:0]  REG_REST  = 2'd0;
  localparam logic [1:0]  REG_AXIS  = 2'd1;
  localparam logic [1:0]  REG_DIAG  = 2'd2;

  localparam logic [WEIGHT_W-1:0] RST_W_REST = 16'd21845;
  localparam logic [WEIGHT_W-1:0] RST_W_AXIS = 16'd3641;
  localparam logic [WEIGHT_W-1:0] RST_W_DIAG = 16'd1820;

  localparam logic [DIR_W-1:0] DIR_REST      = 5'd0;
  localparam logic [DIR_W-1:0] DIR_LAST_AXIS = 5'd6;
  localparam logic [DIR_W-1:0] DIR_LAST      = 5'd18;

  // datapath widths
  localparam int unsigned VSUM_W  = 26;  // sum of up to two signed velocities
  localparam int unsigned CV_W    = 27;  // 3 * (c . v)
  localparam int unsigned CVSQ_W  = 54;  // cv * cv
  localparam int unsigned WPROD_W = 41;  // weight * density
  localparam int unsigned WR_W    = 25;  // rounded weight * density
  localparam int unsigned SUM_W   = 56;  // inner sum at Q.33
  localparam int unsigned INNER_W = 39;  // inner at Q.16
  localparam int unsigned LO_W    = 19;  // low partial of inner, unsigned
  localparam int unsigned HI_W    = INNER_W - LO_W;
  localparam int unsigned PP_W    = 45;  // each partial product
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned Q_W     = PROD_W - 16;

  typedef struct packed {
    logic signed [1:0] cx;
    logic signed [1:0] cy;
    logic signed [1:0] cz;
  } dir_vec_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] rest;
    logic [WEIGHT_W-1:0] axis;
    logic [WEIGHT_W-1:0] diag;
  } weights_t;

  // one direction of one item, sequencer to datapath
  typedef struct packed {
    logic                     valid;
    logic [DIR_W-1:0]         dir;
    logic signed [DATA_W-1:0] density;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic signed [DATA_W-1:0] base_term;
  } beat_t;

  function automatic dir_vec_t dir_vec(input logic [DIR_W-1:0] d);
    dir_vec_t r;
    unique case (d)
      5'd1:    r = '{ 2'sd1,  2'sd0,  2'sd0};
      5'd2:    r = '{-2'sd1,  2'sd0,  2'sd0};
      5'd3:    r = '{ 2'sd0,  2'sd1,  2'sd0};
      5'd4:    r = '{ 2'sd0, -2'sd1,  2'sd0};
      5'd5:    r = '{ 2'sd0,  2'sd0,  2'sd1};
      5'd6:    r = '{ 2'sd0,  2'sd0, -2'sd1};
      5'd7:    r = '{ 2'sd1,  2'sd1,  2'sd0};
      5'd8:    r = '{-2'sd1, -2'sd1,  2'sd0};
      5'd9:    r = '{ 2'sd1, -2'sd1,  2'sd0};
      5'd10:   r = '{-2'sd1,  2'sd1,  2'sd0};
      5'd11:   r = '{ 2'sd1,  2'sd0,  2'sd1};
      5'd12:   r = '{-2'sd1,  2'sd0, -2'sd1};
      5'd13:   r = '{ 2'sd1,  2'sd0, -2'sd1};
      5'd14:   r = '{-2'sd1,  2'sd0,  2'sd1};
      5'd15:   r = '{ 2'sd0, -2'sd1, -2'sd1};
      5'd16:   r = '{ 2'sd0,  2'sd1,  2'sd1};
      5'd17:   r = '{ 2'sd0, -2'sd1,  2'sd1};
      5'd18:   r = '{ 2'sd0,  2'sd1, -2'sd1};
      default: r = '{ 2'sd0,  2'sd0,  2'sd0};
    endcase
    return r;
  endfunction

  // c * v for c in {-1, 0, 1}, sign-extended to the velocity sum width
  function automatic logic signed [VSUM_W-1:0] axis_term(
    input logic signed [DATA_W-1:0] v,
    input logic signed [1:0]        c
  );
    logic signed [VSUM_W-1:0] ve;
    ve = {{(VSUM_W-DATA_W){v[DATA_W-1]}}, v};
    if (c == 2'sd1)
      return ve;
    else if (c == -2'sd1)
      return -ve;
    else
      return '0;
  endfunction

endpackage

### src/lbmeq_channels.sv
// Valid/ready channel interfaces for the equilibrium core: node in, population out.
// Depends on lbmeq_pkg for field widths.
interface lbmeq_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [lbmeq_pkg::DATA_W-1:0]       density;
  logic signed [lbmeq_pkg::DATA_W-1:0]       vel_x;
  logic signed [lbmeq_pkg::DATA_W-1:0]       vel_y;
  logic signed [lbmeq_pkg::DATA_W-1:0]       vel_z;
  logic signed [lbmeq_pkg::DATA_W-1:0]       base_term;

  modport source (output valid, density, vel_x, vel_y, vel_z, base_term, input ready);
  modport sink   (input valid, density, vel_x, vel_y, vel_z, base_term, output ready);
endinterface

interface lbmeq_out_if;
  logic                                      valid;
  logic                                      ready;
  logic [lbmeq_pkg::DIR_W-1:0]               direction;
  logic signed [lbmeq_pkg::DATA_W-1:0]       population;
  logic                                      last;

  modport source (output valid, direction, population, last, input ready);
  modport sink   (input valid, direction, population, last, output ready);
endinterface

### src/lbmeq_cfg.sv
// APB weight registers (rest, axis, diagonal) with read-back.
// Depends on lbmeq_pkg.
module lbmeq_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lbmeq_pkg::ADDR_W-1:0]    paddr,
  input  logic [lbmeq_pkg::CFG_DW-1:0]    pwdata,
  output logic [lbmeq_pkg::CFG_DW-1:0]    prdata,
  output logic                            pready,
  output lbmeq_pkg::weights_t             weights
);

  lbmeq_pkg::weights_t w_r;
  logic                wr_en;
  logic [1:0]          idx;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign weights = w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.rest <= lbmeq_pkg::RST_W_REST;
      w_r.axis <= lbmeq_pkg::RST_W_AXIS;
      w_r.diag <= lbmeq_pkg::RST_W_DIAG;
    end else if (wr_en) begin
      unique case (idx)
        lbmeq_pkg::REG_REST: w_r.rest <= pwdata[lbmeq_pkg::WEIGHT_W-1:0];
        lbmeq_pkg::REG_AXIS: w_r.axis <= pwdata[lbmeq_pkg::WEIGHT_W-1:0];
        lbmeq_pkg::REG_DIAG: w_r.diag <= pwdata[lbmeq_pkg::WEIGHT_W-1:0];
        default: ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      lbmeq_pkg::REG_REST: prdata[lbmeq_pkg::WEIGHT_W-1:0] = w_r.rest;
      lbmeq_pkg::REG_AXIS: prdata[lbmeq_pkg::WEIGHT_W-1:0] = w_r.axis;
      lbmeq_pkg::REG_DIAG: prdata[lbmeq_pkg::WEIGHT_W-1:0] = w_r.diag;
      default:             prdata = '0;
    endcase
  end

endmodule

### src/lbmeq_seq.sv
// Direction sequencer: holds one node and issues its 19 directions, one per advance.
// Depends on lbmeq_pkg and lbmeq_in_if.
module lbmeq_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  lbmeq_in_if.sink             in_if,
  input  logic                 adv,
  output lbmeq_pkg::beat_t     beat
);

  logic                                busy_r, busy_nxt;
  logic [lbmeq_pkg::DIR_W-1:0]         dir_r, dir_nxt;
  logic signed [lbmeq_pkg::DATA_W-1:0] rho_r, vx_r, vy_r, vz_r, base_r;
  logic                                issue, take;

  assign issue       = busy_r & adv;
  assign in_if.ready = ~busy_r | (issue & (dir_r == lbmeq_pkg::DIR_LAST));
  assign take        = in_if.valid & in_if.ready;

  always_comb begin
    busy_nxt = busy_r;
    dir_nxt  = dir_r;
    if (take) begin
      busy_nxt = 1'b1;
      dir_nxt  = lbmeq_pkg::DIR_REST;
    end else if (issue) begin
      if (dir_r == lbmeq_pkg::DIR_LAST) begin
        busy_nxt = 1'b0;
      end else begin
        dir_nxt = dir_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dir_r  <= lbmeq_pkg::DIR_REST;
    end else begin
      busy_r <= busy_nxt;
      dir_r  <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rho_r  <= in_if.density;
      vx_r   <= in_if.vel_x;
      vy_r   <= in_if.vel_y;
      vz_r   <= in_if.vel_z;
      base_r <= in_if.base_term;
    end
  end

  assign beat.valid     = busy_r;
  assign beat.dir       = dir_r;
  assign beat.density   = rho_r;
  assign beat.vel_x     = vx_r;
  assign beat.vel_y     = vy_r;
  assign beat.vel_z     = vz_r;
  assign beat.base_term = base_r;

endmodule

### src/lbmeq_datapath.sv
// Five-stage equilibrium datapath ending in the output register; the whole pipe
// advances together when the output register is empty or being drained.
// Depends on lbmeq_pkg and lbmeq_out_if.
module lbmeq_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lbmeq_pkg::beat_t     beat,
  input  lbmeq_pkg::weights_t  weights,
  output logic                 adv,
  lbmeq_out_if.source          out_if
);

  // stage 1: cv and weight select
  logic                                   s1_vld_r;
  logic [lbmeq_pkg::DIR_W-1:0]            s1_dir_r;
  logic signed [lbmeq_pkg::CV_W-1:0]      s1_cv_r, s1_cv_nxt;
  logic [lbmeq_pkg::WEIGHT_W-1:0]         s1_w_r, s1_w_nxt;
  logic signed [lbmeq_pkg::DATA_W-1:0]    s1_rho_r, s1_base_r;
  lbmeq_pkg::dir_vec_t                    dv;
  logic signed [lbmeq_pkg::VSUM_W-1:0]    vsum;

  // stage 2: cv^2 and w*rho
  logic                                   s2_vld_r;
  logic [lbmeq_pkg::DIR_W-1:0]            s2_dir_r;
  logic signed [lbmeq_pkg::CV_W-1:0]      s2_cv_r;
  logic signed [lbmeq_pkg::CVSQ_W-1:0]    s2_cvsq_r, s2_cvsq_nxt;
  logic signed [lbmeq_pkg::WPROD_W-1:0]   s2_wprod_r, s2_wprod_nxt;
  logic signed [lbmeq_pkg::DATA_W-1:0]    s2_base_r;

  // stage 3: inner sum and rounding
  logic                                   s3_vld_r;
  logic [lbmeq_pkg::DIR_W-1:0]            s3_dir_r;
  logic signed [lbmeq_pkg::SUM_W-1:0]     isum;
  logic signed [lbmeq_pkg::WPROD_W:0]     wsum;
  logic signed [lbmeq_pkg::INNER_W-1:0]   s3_inner_r;
  logic signed [lbmeq_pkg::WR_W-1:0]      s3_wr_r;

  // stage 4: split product
  logic                                   s4_vld_r;
  logic [lbmeq_pkg::DIR_W-1:0]            s4_dir_r;
  logic signed [lbmeq_pkg::PP_W-1:0]      s4_pl_r, s4_pl_nxt, s4_ph_r, s4_ph_nxt;

  // stage 5: recombine, round, saturate into the output register
  logic signed [lbmeq_pkg::PROD_W-1:0]    prod;
  logic signed [lbmeq_pkg::Q_W-1:0]       q;
  logic signed [lbmeq_pkg::DATA_W-1:0]    pop_nxt;
  logic                                   out_vld_r;
  logic [lbmeq_pkg::DIR_W-1:0]            out_dir_r;
  logic signed [lbmeq_pkg::DATA_W-1:0]    out_pop_r;

  assign adv = ~out_vld_r | out_if.ready;

  always_comb begin
    dv   = lbmeq_pkg::dir_vec(beat.dir);
    vsum = lbmeq_pkg::axis_term(beat.vel_x, dv.cx)
         + lbmeq_pkg::axis_term(beat.vel_y, dv.cy)
         + lbmeq_pkg::axis_term(beat.vel_z, dv.cz);
    s1_cv_nxt = {vsum, 1'b0} + {vsum[lbmeq_pkg::VSUM_W-1], vsum};
    if (beat.dir == lbmeq_pkg::DIR_REST)
      s1_w_nxt = weights.rest;
    else if (beat.dir <= lbmeq_pkg::DIR_LAST_AXIS)
      s1_w_nxt = weights.axis;
    else
      s1_w_nxt = weights.diag;
  end

  always_comb begin
    s2_cvsq_nxt  = s1_cv_r * s1_cv_r;
    s2_wprod_nxt = $signed({1'b0, s1_w_r}) * s1_rho_r;
  end

  always_comb begin
    isum = {{15{s2_base_r[lbmeq_pkg::DATA_W-1]}}, s2_base_r, 17'b0}
         + {{2{s2_cvsq_r[lbmeq_pkg::CVSQ_W-1]}}, s2_cvsq_r}
         + {{12{s2_cv_r[lbmeq_pkg::CV_W-1]}}, s2_cv_r, 17'b0}
         + 56'sd65536;
    wsum = {s2_wprod_r[lbmeq_pkg::WPROD_W-1], s2_wprod_r} + 42'sd32768;
  end

  always_comb begin
    s4_pl_nxt = s3_wr_r * $signed({1'b0, s3_inner_r[lbmeq_pkg::LO_W-1:0]});
    s4_ph_nxt = s3_wr_r * $signed(s3_inner_r[lbmeq_pkg::INNER_W-1:lbmeq_pkg::LO_W]);
  end

  always_comb begin
    prod = {{19{s4_ph_r[lbmeq_pkg::PP_W-1]}}, s4_ph_r[lbmeq_pkg::PP_W-1:0]} <<< 19;
    prod = prod + {{19{s4_pl_r[lbmeq_pkg::PP_W-1]}}, s4_pl_r} + 64'sd32768;
    q    = prod[lbmeq_pkg::PROD_W-1:16];
    // in range when the bits above the Q8.16 sign all match it
    if (q[lbmeq_pkg::Q_W-1:lbmeq_pkg::DATA_W-1] == '0 ||
        q[lbmeq_pkg::Q_W-1:lbmeq_pkg::DATA_W-1] == '1)
      pop_nxt = q[lbmeq_pkg::DATA_W-1:0];
    else if (q[lbmeq_pkg::Q_W-1])
      pop_nxt = {1'b1, {(lbmeq_pkg::DATA_W-1){1'b0}}};
    else
      pop_nxt = {1'b0, {(lbmeq_pkg::DATA_W-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= beat.valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dir_r   <= beat.dir;
      s1_cv_r    <= s1_cv_nxt;
      s1_w_r     <= s1_w_nxt;
      s1_rho_r   <= beat.density;
      s1_base_r  <= beat.base_term;

      s2_dir_r   <= s1_dir_r;
      s2_cv_r    <= s1_cv_r;
      s2_cvsq_r  <= s2_cvsq_nxt;
      s2_wprod_r <= s2_wprod_nxt;
      s2_base_r  <= s1_base_r;

      s3_dir_r   <= s2_dir_r;
      s3_inner_r <= isum[lbmeq_pkg::SUM_W-1:17];
      s3_wr_r    <= wsum[lbmeq_pkg::WPROD_W-1:16];

      s4_dir_r   <= s3_dir_r;
      s4_pl_r    <= s4_pl_nxt;
      s4_ph_r    <= s4_ph_nxt;

      out_dir_r  <= s4_dir_r;
      out_pop_r  <= pop_nxt;
    end
  end

  assign out_if.valid      = out_vld_r;
  assign out_if.direction  = out_dir_r;
  assign out_if.population = out_pop_r;
  assign out_if.last       = (out_dir_r == lbmeq_pkg::DIR_LAST);

endmodule

### src/lbm_d3q19_equilibrium_core.sv
// D3Q19 lattice Boltzmann equilibrium core, top level.
// Depends on lbmeq_pkg, lbmeq_channels, lbmeq_cfg, lbmeq_seq, lbmeq_datapath.
//
// Each accepted node item (density, vel_x/y/z, base_term, all signed Q8.16)
// yields 19 result items, direction 0 to 18 in order, last set on 18. Each
// population is w_d*rho*(base + 4.5(c.u)^2 + 3(c.u)), rounded half up at every
// scaling step and saturated to Q8.16. Throughput is one result per cycle while
// the result sink is ready; the next node is accepted in the same cycle that the
// sequencer issues direction 18 of the current one, so the output stream runs
// without gaps while the input keeps up. The figure is set by the single
// result channel, which carries one population per cycle. From input acceptance
// to the first result an item passes the sequencer hold, four arithmetic
// stages and the output register. When the result sink stalls the whole
// pipe freezes in place; nothing is dropped or repeated. Weights live in three
// APB registers at byte addresses 0 (rest), 4 (axis), 8 (diagonal), unsigned
// Q0.16, reset to 1/3, 1/18 and 1/36; write them only while the core is idle.
module lbm_d3q19_equilibrium_core (
  input  logic                           clk,
  input  logic                           rst_n,
  lbmeq_in_if.sink                       in_if,
  lbmeq_out_if.source                    out_if,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [lbmeq_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [lbmeq_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [lbmeq_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                           cfg_pready
);

  lbmeq_pkg::weights_t weights;   // current weight registers
  lbmeq_pkg::beat_t    beat;      // one direction of the held node
  logic                adv;       // pipe advance, from output back-pressure

  lbmeq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .weights (weights)
  );

  // holds the node and walks directions 0..18
  lbmeq_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .adv   (adv),
    .beat  (beat)
  );

  // cv / weight select -> multiplies -> inner sum -> split product -> saturate
  lbmeq_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat    (beat),
    .weights (weights),
    .adv     (adv),
    .out_if  (out_if)
  );

endmodule
